/* hdl/gbdi_pkg.sv */
// Shared package for the gyro bias / deadband integrator.
// Widths, reset values, register indexes and controller/datapath structs.
// No dependencies.
`default_nettype none

package gbdi_pkg;

    localparam int TIME_W    = 32;
    localparam int RATE_W    = 16;
    localparam int ANGLE_W   = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = 48;
    localparam int MAG_W     = RATE_W + 1;
    localparam int MUL_A_W   = RATE_W + 2;          // rate minus bias, signed
    localparam int MUL_B_W   = TIME_W + 1;          // elapsed, zero extended
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int DIV_W     = 52;                  // even, holds PROD_W and SUM_W
    localparam int DVSR_W    = 16;
    localparam int REM_W     = DVSR_W + 1;
    localparam int DIV_STEPS = DIV_W / 2;           // two quotient bits per cycle
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam int AXIS_SLOTS   = 3;
    localparam int NUM_AXES_DEF = 3;

    localparam logic [CFG_W-1:0]  START_DELAY_RST = 16'd2000;
    localparam logic [CFG_W-1:0]  CALIB_DUR_RST   = 16'd5000;
    localparam logic [DVSR_W-1:0] MS_PER_S        = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB_DUR   = 2'd1;

    typedef enum logic {MUL_CAL, MUL_INT}    t_mul_sel;
    typedef enum logic {DIV_BIAS, DIV_DELTA} t_div_sel;

    typedef struct packed {
        logic     cap;        // capture input item
        logic     eval;       // take elapsed time, update previous time
        logic     axis_clr;
        logic     axis_inc;
        logic     mul_go;
        t_mul_sel mul_sel;
        logic     acc_cal;    // calibration accumulate and peak update
        logic     div_go;
        t_div_sel div_sel;
        logic     bias_ld;
        logic     angle_add;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic ignore;
        logic in_calib;
        logic pass;           // current axis is above the deadband
        logic axis_last;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* hdl/gbdi_div.sv */
// Serial signed-by-unsigned divider, two quotient bits per cycle, truncating.
// Depends on gbdi_pkg.
`default_nettype none

module gbdi_div import gbdi_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_go,
    input  wire logic signed [DIV_W-1:0]  i_dividend,
    input  wire logic [DVSR_W-1:0]        i_divisor,
    output logic                          o_busy,
    output logic                          o_done,
    output logic signed [DIV_W-1:0]       o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_num;
    logic [REM_W-1:0]     r_rem;
    logic [DVSR_W-1:0]    r_dvsr;
    logic signed [DIV_W-1:0] r_quo;

    logic [DIV_W+REM_W-1:0] n_s1;
    logic [DIV_W+REM_W-1:0] n_s2;

    // one restoring step: shift in next dividend bit, subtract if it fits
    function automatic logic [DIV_W+REM_W-1:0] div_step(
        input logic [REM_W-1:0]  rem,
        input logic [DIV_W-1:0]  num,
        input logic [DVSR_W-1:0] d
    );
        logic [REM_W-1:0] t;
        logic             qb;
        t  = {rem[REM_W-2:0], num[DIV_W-1]};
        qb = (t >= {1'b0, d});
        if (qb) begin
            t = t - {1'b0, d};
        end
        return {t, num[DIV_W-2:0], qb};
    endfunction

    always_comb begin
        n_s1 = div_step(r_rem, r_num, r_dvsr);
        n_s2 = div_step(n_s1[DIV_W+REM_W-1:DIV_W], n_s1[DIV_W-1:0], r_dvsr);
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            r_neg  <= i_dividend[DIV_W-1];
            r_num  <= i_dividend[DIV_W-1] ? DIV_W'(-i_dividend) : i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_num <= n_s2[DIV_W-1:0];
            r_rem <= n_s2[DIV_W+REM_W-1:DIV_W];
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
                r_quo  <= r_neg ? DIV_W'(-n_s2[DIV_W-1:0]) : n_s2[DIV_W-1:0];
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

/* hdl/gbdi_datapath.sv */
// Datapath: config registers, per-axis calibration and angle state,
// shared multiplier, serial divider and output register.
// Depends on gbdi_pkg and gbdi_div.
`default_nettype none

module gbdi_datapath import gbdi_pkg::*; #(
    parameter int NUM_AXES = NUM_AXES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [CFG_W-1:0]           i_cfg_data,
    input  wire logic [TIME_W-1:0]          i_time_ms,
    input  wire logic signed [RATE_W-1:0]   i_rate [AXIS_SLOTS],
    input  wire logic                       i_out_ready,
    input  wire t_cmd                       i_cmd,
    output t_sts                            o_sts,
    output logic                            o_out_valid,
    output logic signed [ANGLE_W-1:0]       o_angle [AXIS_SLOTS]
);

    localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    logic [CFG_W-1:0]            r_start_delay;
    logic [CFG_W-1:0]            r_calib_dur;
    logic [TIME_W-1:0]           r_time;
    logic signed [RATE_W-1:0]    r_rate  [NUM_AXES];
    logic                        r_started;
    logic [TIME_W-1:0]           r_prev_time;
    logic [TIME_W-1:0]           r_elapsed;
    logic [AXW-1:0]              r_axis;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [RATE_W-1:0]    r_bias;
    logic signed [SUM_W-1:0]     r_sum   [NUM_AXES];
    logic [RATE_W-1:0]           r_peak  [NUM_AXES];
    logic signed [ANGLE_W-1:0]   r_angle [NUM_AXES];
    logic signed [ANGLE_W-1:0]   r_out   [NUM_AXES];
    logic                        r_out_valid;

    logic signed [RATE_W-1:0]    cur_rate;
    logic signed [MAG_W-1:0]     rate_ext;
    logic [MAG_W-1:0]            mag;
    logic [TIME_W:0]             calib_end;
    logic [TIME_W-1:0]           prev_eff;
    logic [TIME_W-1:0]           n_elapsed;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]    mul_p;
    logic signed [DIV_W-1:0]     div_num;
    logic [DVSR_W-1:0]           div_den;
    logic signed [DIV_W-1:0]     div_q;
    logic                        div_busy;
    logic                        div_done;
    logic                        q_fits;
    logic signed [RATE_W-1:0]    bias_clip;
    logic                        out_free;

    assign cur_rate  = r_rate[r_axis];
    assign rate_ext  = MAG_W'(cur_rate);
    assign mag       = rate_ext[MAG_W-1] ? MAG_W'(-rate_ext) : rate_ext;
    assign calib_end = {1'b0, {(TIME_W-CFG_W){1'b0}}, r_start_delay}
                     + {1'b0, {(TIME_W-CFG_W){1'b0}}, r_calib_dur};
    assign prev_eff  = r_started ? r_prev_time : TIME_W'(r_start_delay);
    assign n_elapsed = (r_time >= prev_eff) ? (r_time - prev_eff) : '0;
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts           = '0;
        o_sts.ignore    = (r_time <= TIME_W'(r_start_delay));
        o_sts.in_calib  = ({1'b0, r_time} < calib_end);
        o_sts.pass      = (mag > {r_peak[r_axis], 1'b0});
        o_sts.axis_last = (r_axis == AXW'(NUM_AXES - 1));
        o_sts.div_busy  = div_busy;
        o_sts.div_done  = div_done;
        o_sts.out_free  = out_free;
    end

    // shared multiplier operands
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_CAL: mul_a = MUL_A_W'(cur_rate);
            default: mul_a = MUL_A_W'(cur_rate) - MUL_A_W'(r_bias);
        endcase
        mul_b = $signed({1'b0, r_elapsed});
        mul_p = mul_a * mul_b;
    end

    // divider operands: bias = sum / duration, delta = product / 1000
    always_comb begin
        case (i_cmd.div_sel)
            DIV_BIAS: begin
                div_num = DIV_W'(r_sum[r_axis]);
                div_den = (r_calib_dur == '0) ? DVSR_W'(1) : r_calib_dur;
            end
            default: begin
                div_num = DIV_W'(r_prod);
                div_den = MS_PER_S;
            end
        endcase
    end

    // clip quotient to the rate range
    assign q_fits    = (&div_q[DIV_W-1:RATE_W-1]) || !(|div_q[DIV_W-1:RATE_W-1]);
    assign bias_clip = q_fits ? div_q[RATE_W-1:0]
                     : (div_q[DIV_W-1] ? {1'b1, {(RATE_W-1){1'b0}}}
                                       : {1'b0, {(RATE_W-1){1'b1}}});

    gbdi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_cmd.div_go),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_START_DELAY: r_start_delay <= i_cfg_data;
                REG_CALIB_DUR:   r_calib_dur   <= i_cfg_data;
                default: ;
            endcase
        end

        if (i_cmd.cap) begin
            r_time <= i_time_ms;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_rate[a] <= i_rate[a];
            end
        end

        if (i_cmd.eval) begin
            r_started   <= 1'b1;
            r_prev_time <= r_time;
            r_elapsed   <= n_elapsed;
        end

        if (i_cmd.axis_clr) begin
            r_axis <= '0;
        end else if (i_cmd.axis_inc) begin
            r_axis <= r_axis + 1'b1;
        end

        if (i_cmd.mul_go) begin
            r_prod <= mul_p;
        end

        if (i_cmd.acc_cal) begin
            r_sum[r_axis] <= r_sum[r_axis] + r_prod[SUM_W-1:0];
            if (mag > MAG_W'(r_peak[r_axis])) begin
                r_peak[r_axis] <= mag[RATE_W-1:0];
            end
        end

        if (i_cmd.bias_ld) begin
            r_bias <= bias_clip;
        end

        if (i_cmd.angle_add) begin
            r_angle[r_axis] <= r_angle[r_axis] + div_q[ANGLE_W-1:0];
        end

        if (r_out_valid && i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_out[a] <= r_angle[a];
            end
        end

        if (!i_rst_n) begin
            r_start_delay <= START_DELAY_RST;
            r_calib_dur   <= CALIB_DUR_RST;
            r_started     <= 1'b0;
            r_prev_time   <= '0;
            r_axis        <= '0;
            r_out_valid   <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_sum[a]   <= '0;
                r_peak[a]  <= '0;
                r_angle[a] <= '0;
            end
        end
    end

    for (genvar g = 0; g < AXIS_SLOTS; g++) begin : g_out
        if (g < NUM_AXES) begin : g_live
            assign o_angle[g] = r_out[g];
        end else begin : g_zero
            assign o_angle[g] = '0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* hdl/gbdi_ctrl.sv */
// Controller FSM: sequences capture, calibration and integration per axis.
// Depends on gbdi_pkg.
`default_nettype none

module gbdi_ctrl import gbdi_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_EVAL, S_CMUL, S_CACC, S_TEST,
        S_BWAIT, S_IMUL, S_DGO, S_DWAIT, S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_CAL;
        o_cmd.div_sel = DIV_BIAS;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.cap = i_in_valid;
                if (i_in_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.ignore) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.eval     = 1'b1;
                    o_cmd.axis_clr = 1'b1;
                    n_state        = i_sts.in_calib ? S_CMUL : S_TEST;
                end
            end
            S_CMUL: begin
                o_cmd.mul_go = 1'b1;
                n_state      = S_CACC;
            end
            S_CACC: begin
                o_cmd.acc_cal = 1'b1;
                if (i_sts.axis_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.axis_inc = 1'b1;
                    n_state        = S_CMUL;
                end
            end
            S_TEST: begin
                if (i_sts.pass) begin
                    o_cmd.div_go = 1'b1;
                    n_state      = S_BWAIT;
                end else if (i_sts.axis_last) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.axis_inc = 1'b1;
                end
            end
            S_BWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.bias_ld = 1'b1;
                    n_state       = S_IMUL;
                end
            end
            S_IMUL: begin
                o_cmd.mul_sel = MUL_INT;
                o_cmd.mul_go  = 1'b1;
                n_state       = S_DGO;
            end
            S_DGO: begin
                o_cmd.div_sel = DIV_DELTA;
                o_cmd.div_go  = 1'b1;
                n_state       = S_DWAIT;
            end
            S_DWAIT: begin
                o_cmd.div_sel = DIV_DELTA;
                if (i_sts.div_done) begin
                    o_cmd.angle_add = 1'b1;
                    if (i_sts.axis_last) begin
                        n_state = S_EMIT;
                    end else begin
                        o_cmd.axis_inc = 1'b1;
                        n_state        = S_TEST;
                    end
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

/* hdl/gyro_bias_deadband_integrator.sv */
// Gyro rate integrator with start delay, bias calibration and deadband.
// Top level: joins gbdi_ctrl and gbdi_datapath; depends on gbdi_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries a ms timestamp and three
//   signed rates. One item is worked at a time; o_in_ready is high only while
//   the controller is idle.
//   Items at or before start_delay_ms are dropped with no result.
//   Calibration items accumulate rate*elapsed and the peak |rate| per axis,
//   with no result.
//   Later items emit one result on o_out_valid / i_out_ready with the three
//   angles. An axis at or below twice its peak is skipped; an axis that
//   passes takes two runs of the shared serial divider (bias = sum /
//   duration, then delta = product / 1000, each at two quotient bits per
//   cycle).
//   The result sits in an output register; the next item is accepted while
//   it waits. If the receiver stalls, a second result waits in the angle
//   registers until the output register frees; input stays blocked meanwhile.
//   Reset (i_rst_n low, synchronous) restores config defaults (2000 ms delay,
//   5000 ms window) and clears sums, peaks, angles and the start flag.
//   Config writes (i_cfg_we) take effect at once; write only while idle.
`default_nettype none

module gyro_bias_deadband_integrator import gbdi_pkg::*; #(
    parameter int NUM_AXES = NUM_AXES_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [CFG_W-1:0]         i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [TIME_W-1:0]        i_time_ms,
    input  wire logic signed [RATE_W-1:0] i_rate_roll,
    input  wire logic signed [RATE_W-1:0] i_rate_pitch,
    input  wire logic signed [RATE_W-1:0] i_rate_yaw,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic signed [ANGLE_W-1:0]     o_roll_angle,
    output logic signed [ANGLE_W-1:0]     o_pitch_angle,
    output logic signed [ANGLE_W-1:0]     o_yaw_angle
);

    t_cmd                      cmd;
    t_sts                      sts;
    logic signed [RATE_W-1:0]  rates  [AXIS_SLOTS];
    logic signed [ANGLE_W-1:0] angles [AXIS_SLOTS];

    assign rates[0] = i_rate_roll;
    assign rates[1] = i_rate_pitch;
    assign rates[2] = i_rate_yaw;

    gbdi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    gbdi_datapath #(
        .NUM_AXES (NUM_AXES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_time_ms   (i_time_ms),
        .i_rate      (rates),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_angle     (angles)
    );

    // roll, pitch, yaw in axis order
    assign o_roll_angle  = angles[0];
    assign o_pitch_angle = angles[1];
    assign o_yaw_angle   = angles[2];

`ifndef SYNTHESIS
    // a pending result is never overwritten
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result loaded while output register still full");

    // divider is never restarted mid-run
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_go |-> !sts.div_busy)
        else $error("divider started while busy");

    // angle update only on a fresh quotient
    a_add_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.angle_add |-> sts.div_done)
        else $error("angle updated without divider result");

    // one item in flight: after a transfer the input closes
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item accepted while one is in work");
`endif

endmodule

`default_nettype wire
